[rtl/core/irrigation_zone_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// irrigation zone sequencer assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef IRRIGATION_ZONE_SEQUENCER_CORE_DEFINES_SVH
`define IRRIGATION_ZONE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IZS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define IZS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/izs_pkg.sv]
// ----------------------------------------------------------------------------
// izs_pkg
// types and constants of the irrigation zone sequencer
// ----------------------------------------------------------------------------
package izs_pkg;

    localparam int ZONES      = 6;
    localparam int SCHED_REGS = 6;
    localparam int OUT_W      = 6;

    localparam int FUNC_W = 3;
    localparam int ZONE_W = 3;
    localparam int SECS_W = 16;
    localparam int MS_W   = 32;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int WDAY_W = 3;
    localparam int REM_W  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_RAIN_OVR = 3'd6;

    localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ON     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_OFF    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ALLOFF = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RUN    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RAIN   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_STATUS = 3'd6;

    // duration in ms fits 26 bits
    localparam int DUR_MS_W = 26;
    localparam int MS_PER_S = 1000;

    // floor(x / 1000) == (x * RECIP_MAGIC) >> RECIP_SHIFT for any 32-bit x
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_MAGIC = 29'd274877907;
    localparam int PROD_W = MS_W + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic latch;
        logic exec;
        logic start;
        logic calc;
        logic mul;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
    } t_dp_stat;

endpackage

[rtl/core/izs_cmd_if.sv]
// ----------------------------------------------------------------------------
// izs_cmd_if
// command channel: valid/ready plus command payload
// ----------------------------------------------------------------------------
interface izs_cmd_if import izs_pkg::*;;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ZONE_W-1:0] zone_index;
    logic [SECS_W-1:0] run_seconds;
    logic [MS_W-1:0]   now_ms;
    logic [HOUR_W-1:0] hour_now;
    logic [MIN_W-1:0]  minute_now;
    logic [WDAY_W-1:0] weekday_now;
    logic              time_synced;
    logic              rain_pin;

    modport source (
        output valid, func, zone_index, run_seconds, now_ms, hour_now,
               minute_now, weekday_now, time_synced, rain_pin,
        input  ready
    );

    modport sink (
        input  valid, func, zone_index, run_seconds, now_ms, hour_now,
               minute_now, weekday_now, time_synced, rain_pin,
        output ready
    );

endinterface

[rtl/core/izs_res_if.sv]
// ----------------------------------------------------------------------------
// izs_res_if
// result channel: valid/ready plus relay and status payload
// ----------------------------------------------------------------------------
interface izs_res_if import izs_pkg::*;;

    logic                    valid;
    logic                    ready;
    logic [OUT_W-1:0]        relay_drive;
    logic [OUT_W-1:0]        active_mask;
    logic                    rain_flag;
    logic                    zone_running;
    logic signed [REM_W-1:0] remaining_seconds;

    modport source (
        output valid, relay_drive, active_mask, rain_flag, zone_running,
               remaining_seconds,
        input  ready
    );

    modport sink (
        input  valid, relay_drive, active_mask, rain_flag, zone_running,
               remaining_seconds,
        output ready
    );

endinterface

[rtl/core/izs_ctrl.sv]
// ----------------------------------------------------------------------------
// izs_ctrl
// sequencing state machine: accept, execute, schedule start, divide, output
// ----------------------------------------------------------------------------
module izs_ctrl
    import izs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.is_tick ? S_START : S_CALC;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/izs_dp.sv]
// ----------------------------------------------------------------------------
// izs_dp
// zone lanes, schedule registers, rain state and remaining-time divider
// ----------------------------------------------------------------------------
module izs_dp
    import izs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [ZONE_W-1:0]       i_zone_index,
    input  logic [SECS_W-1:0]       i_run_seconds,
    input  logic [MS_W-1:0]         i_now_ms,
    input  logic [HOUR_W-1:0]       i_hour_now,
    input  logic [MIN_W-1:0]        i_minute_now,
    input  logic [WDAY_W-1:0]       i_weekday_now,
    input  logic                    i_time_synced,
    input  logic                    i_rain_pin,
    output logic [OUT_W-1:0]        o_relay_drive,
    output logic [OUT_W-1:0]        o_active_mask,
    output logic                    o_rain_flag,
    output logic                    o_zone_running,
    output logic signed [REM_W-1:0] o_remaining_seconds
);

    // latched transaction
    logic [FUNC_W-1:0] r_func;
    logic [ZONE_W-1:0] r_zone;
    logic [SECS_W-1:0] r_secs;
    logic [MS_W-1:0]   r_now;
    logic [HOUR_W-1:0] r_hour;
    logic [MIN_W-1:0]  r_min;
    logic [WDAY_W-1:0] r_wday;
    logic              r_synced;
    logic              r_raining;

    // configuration
    logic [CFG_DATA_W-1:0] r_sched [SCHED_REGS];
    logic                  r_rain_ovr;

    // zone state
    logic [ZONES-1:0]  r_act;
    logic [MS_W-1:0]   r_start [ZONES];
    logic [SECS_W-1:0] r_ovr   [ZONES];
    logic              r_rain_seen;

    // remaining-time path
    logic [MS_W-1:0]   r_diff;
    logic [SECS_W-1:0] r_dur;
    logic              r_zact;
    logic [PROD_W-1:0] r_prod;

    // output register
    logic [OUT_W-1:0]        r_o_drive;
    logic [OUT_W-1:0]        r_o_mask;
    logic                    r_o_rain;
    logic                    r_o_run;
    logic signed [REM_W-1:0] r_o_rem;

    // lane signals
    logic [CFG_DATA_W-1:0] lane_w    [ZONES];
    logic [SECS_W-1:0]     lane_dur  [ZONES];
    logic [MS_W-1:0]       lane_diff [ZONES];
    logic [ZONES-1:0]      lane_sel;
    logic [ZONES-1:0]      lane_exp;
    logic [ZONES-1:0]      lane_match;
    logic [ZONES-1:0]      lane_pick;
    logic [ZONES-1:0]      lane_off;
    logic [ZONES-1:0]      lane_on;
    logic [ZONES-1:0]      lane_ovr_wr;
    logic [OUT_W-1:0]      out_act;

    logic              zone_ok;
    logic              rain_stop;
    logic              start_en;
    logic              found;
    logic [MS_W-1:0]   sel_diff;
    logic [SECS_W-1:0] sel_dur;
    logic              sel_act;
    logic [QUOT_W-1:0] quot;

    assign o_stat.is_tick = (r_func == FN_TICK);
    assign zone_ok        = (r_zone < ZONE_W'(ZONES));
    assign rain_stop      = (r_func == FN_RAIN) && (r_raining != r_rain_seen)
                            && r_raining && r_rain_ovr;
    assign start_en       = i_cmd.start && r_synced && !(r_rain_seen && r_rain_ovr)
                            && !(|r_act);

    for (genvar i = 0; i < ZONES; i++) begin : g_lane
        logic [DUR_MS_W-1:0] dur_ms;
        logic [7:0]          days;

        if (i < SCHED_REGS) begin : g_sched
            assign lane_w[i] = r_sched[i];
        end else begin : g_nosched
            assign lane_w[i] = '0;
        end

        assign lane_dur[i]  = (r_ovr[i] != '0) ? r_ovr[i] : lane_w[i][34:19];
        assign dur_ms       = DUR_MS_W'(lane_dur[i]) * DUR_MS_W'(MS_PER_S);
        assign lane_diff[i] = r_now - r_start[i];
        // whole seconds reach the duration exactly when ms reach duration * 1000
        assign lane_exp[i]  = r_act[i] && (MS_W'(dur_ms) <= lane_diff[i]);
        assign days         = {1'b0, lane_w[i][7:1]};
        assign lane_match[i] = lane_w[i][0] && days[r_wday]
                               && (r_hour == lane_w[i][12:8])
                               && (r_min == lane_w[i][18:13]);
        assign lane_sel[i]  = zone_ok && (r_zone == ZONE_W'(i));
    end

    // lowest-numbered matching zone wins
    always_comb begin
        found     = 1'b0;
        lane_pick = '0;
        for (int i = 0; i < ZONES; i++) begin
            if (lane_match[i] && !found) begin
                lane_pick[i] = 1'b1;
                found        = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < ZONES; i++) begin
            lane_off[i] = i_cmd.exec && (
                ((r_func == FN_TICK) && r_synced && lane_exp[i]) ||
                ((r_func == FN_OFF) && lane_sel[i]) ||
                (r_func == FN_ALLOFF) || rain_stop);
            lane_on[i] = (i_cmd.exec && ((r_func == FN_ON) || (r_func == FN_RUN))
                          && lane_sel[i]) || (start_en && lane_pick[i]);
            lane_ovr_wr[i] = i_cmd.exec && (r_func == FN_RUN) && lane_sel[i];
        end
    end

    always_comb begin
        sel_diff = '0;
        sel_dur  = '0;
        sel_act  = 1'b0;
        for (int i = 0; i < ZONES; i++) begin
            if (lane_sel[i]) begin
                sel_diff = lane_diff[i];
                sel_dur  = lane_dur[i];
                sel_act  = r_act[i];
            end
        end
    end

    for (genvar j = 0; j < OUT_W; j++) begin : g_out
        if (j < ZONES) begin : g_zone
            assign out_act[j] = r_act[j];
        end else begin : g_none
            assign out_act[j] = 1'b0;
        end
    end

    assign quot = r_prod[PROD_W-1:RECIP_SHIFT];

    // transaction latch and remaining-time pipeline, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func    <= i_func;
            r_zone    <= i_zone_index;
            r_secs    <= i_run_seconds;
            r_now     <= i_now_ms;
            r_hour    <= i_hour_now;
            r_min     <= i_minute_now;
            r_wday    <= i_weekday_now;
            r_synced  <= i_time_synced;
            r_raining <= !i_rain_pin;
        end
        if (i_cmd.calc) begin
            r_diff <= sel_diff;
            r_dur  <= sel_dur;
            r_zact <= sel_act;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_diff) * PROD_W'(RECIP_MAGIC);
        end
        if (i_cmd.fin) begin
            r_o_drive <= ~out_act;
            r_o_mask  <= out_act;
            r_o_rain  <= r_rain_seen;
            r_o_run   <= r_zact;
            r_o_rem   <= r_zact ? (REM_W'(r_dur) - REM_W'(quot)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCHED_REGS; i++) begin
                r_sched[i] <= '0;
            end
            r_rain_ovr  <= 1'b0;
            r_act       <= '0;
            r_rain_seen <= 1'b0;
            for (int i = 0; i < ZONES; i++) begin
                r_start[i] <= '0;
                r_ovr[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                for (int i = 0; i < SCHED_REGS; i++) begin
                    if (i_cfg_idx == CFG_IDX_W'(i)) begin
                        r_sched[i] <= i_cfg_data;
                    end
                end
                if (i_cfg_idx == CFG_RAIN_OVR) begin
                    r_rain_ovr <= i_cfg_data[0];
                end
            end
            if (i_cmd.exec && (r_func == FN_RAIN) && (r_raining != r_rain_seen)) begin
                r_rain_seen <= r_raining;
            end
            for (int i = 0; i < ZONES; i++) begin
                if (lane_off[i]) begin
                    r_act[i]   <= 1'b0;
                    r_start[i] <= '0;
                    r_ovr[i]   <= '0;
                end else if (lane_on[i]) begin
                    r_act[i]   <= 1'b1;
                    r_start[i] <= r_now;
                end
                if (lane_ovr_wr[i]) begin
                    r_ovr[i] <= r_secs;
                end
            end
        end
    end

    assign o_relay_drive       = r_o_drive;
    assign o_active_mask       = r_o_mask;
    assign o_rain_flag         = r_o_rain;
    assign o_zone_running      = r_o_run;
    assign o_remaining_seconds = r_o_rem;

endmodule

[rtl/core/irrigation_zone_sequencer_core.sv]
// ----------------------------------------------------------------------------
// irrigation_zone_sequencer_core
// six-zone watering relay sequencer with schedule, manual and rain control
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  i_cmd     in   valid / ready    command, wall time, rain pin
//  o_res     out  valid / ready    relay drive, mask, rain, zone remaining s
//  i_cfg_*   in   write enable     schedule words 0..5, rain override 6
//
//  the result is registered through execute, schedule start (tick only),
//  capture, multiply and the output register
//  the divide by 1000 is one 32x29 multiply
//  i_cmd.ready is high only while idle; a command holds the block until its
//  result is taken, so stalls on o_res hold it longer
//  synchronous active-low reset clears zone state, rain state and config
// ----------------------------------------------------------------------------
module irrigation_zone_sequencer_core
    import izs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    izs_cmd_if.sink               i_cmd,
    izs_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    izs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    izs_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_func              (i_cmd.func),
        .i_zone_index        (i_cmd.zone_index),
        .i_run_seconds       (i_cmd.run_seconds),
        .i_now_ms            (i_cmd.now_ms),
        .i_hour_now          (i_cmd.hour_now),
        .i_minute_now        (i_cmd.minute_now),
        .i_weekday_now       (i_cmd.weekday_now),
        .i_time_synced       (i_cmd.time_synced),
        .i_rain_pin          (i_cmd.rain_pin),
        .o_relay_drive       (o_res.relay_drive),
        .o_active_mask       (o_res.active_mask),
        .o_rain_flag         (o_res.rain_flag),
        .o_zone_running      (o_res.zone_running),
        .o_remaining_seconds (o_res.remaining_seconds)
    );

endmodule

[rtl/core/izs_checker.sv]
// ----------------------------------------------------------------------------
// izs_checker
// port-level checks on the sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "irrigation_zone_sequencer_core_defines.svh"

module izs_checker
    import izs_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [OUT_W-1:0]        i_relay_drive,
    input logic [OUT_W-1:0]        i_active_mask,
    input logic                    i_zone_running,
    input logic signed [REM_W-1:0] i_remaining_seconds
);

    // one transaction in flight at a time
    `IZS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")
    `IZS_ASSERT_SAME(a_no_accept_pending, i_out_valid, !i_in_ready, "accept with result pending")
    // relays are the active-low image of the mask
    `IZS_ASSERT_SAME(a_drive_mask, i_out_valid, i_relay_drive == ~i_active_mask, "relay/mask mismatch")
    `IZS_ASSERT_SAME(a_idle_rem_zero, i_out_valid && !i_zone_running, i_remaining_seconds == '0, "idle zone remaining nonzero")
    `IZS_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_remaining_seconds), "stalled result changed")

endmodule

bind irrigation_zone_sequencer_core izs_checker u_izs_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_cmd.valid),
    .i_in_ready          (i_cmd.ready),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_relay_drive       (o_res.relay_drive),
    .i_active_mask       (o_res.active_mask),
    .i_zone_running      (o_res.zone_running),
    .i_remaining_seconds (o_res.remaining_seconds)
);

[tb/irrigation_zone_sequencer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrigation_zone_sequencer_core_tb
// self-checking bench: directed zone, schedule and rain cases, backpressure,
// then random command traffic under changing idle/stall mixes, every status
// transaction compared against a cycle-free behavioral predictor
// ----------------------------------------------------------------------------
module irrigation_zone_sequencer_core_tb
    import izs_pkg::*;
;

    localparam logic [FUNC_W-1:0]    FN_SPARE       = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_MIX = 100;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [ZONE_W-1:0] zone;
        logic [SECS_W-1:0] secs;
        logic [MS_W-1:0]   now;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [WDAY_W-1:0] wday;
        logic              synced;
        logic              rain_pin;
    } t_zone_cmd;

    typedef struct {
        logic [OUT_W-1:0]        drive;
        logic [OUT_W-1:0]        active;
        logic                    rain;
        logic                    running;
        logic signed [REM_W-1:0] remain;
    } t_relay_status;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    izs_cmd_if cmd_if ();
    izs_res_if res_if ();

    irrigation_zone_sequencer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    bit                  zone_on  [ZONES];
    bit [MS_W-1:0]       zone_t0  [ZONES];
    bit [SECS_W-1:0]     zone_ovr [ZONES];
    bit                  rain_seen_q;
    bit [CFG_DATA_W-1:0] sched_word [SCHED_REGS];
    bit                  rain_ovr_q;

    t_relay_status pending_status[$];
    int mismatch_cnt;
    int cmds_sent;
    int status_seen;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_cycles;
    bit [MS_W-1:0] wall_ms;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[irrigation_zone_sequencer_core] ERROR");
        $finish;
    end

    function automatic void clear_model();
        for (int i = 0; i < ZONES; i++) begin
            zone_on[i]  = 1'b0;
            zone_t0[i]  = '0;
            zone_ovr[i] = '0;
        end
        for (int i = 0; i < SCHED_REGS; i++) sched_word[i] = '0;
        rain_seen_q = 1'b0;
        rain_ovr_q  = 1'b0;
    endfunction

    function automatic bit [SECS_W-1:0] run_limit(int z);
        return (zone_ovr[z] != 0) ? zone_ovr[z] : sched_word[z][34:19];
    endfunction

    function automatic bit [MS_W-1:0] secs_elapsed(int z, bit [MS_W-1:0] now);
        bit [MS_W-1:0] delta;
        delta = now - zone_t0[z];
        return delta / MS_PER_S;
    endfunction

    function automatic void set_zone(int z, bit on, bit [MS_W-1:0] now);
        if (z >= ZONES) return;
        zone_on[z] = on;
        zone_t0[z] = on ? now : '0;
        if (!on) zone_ovr[z] = '0;
    endfunction

    function automatic void drop_all_zones(bit [MS_W-1:0] now);
        for (int i = 0; i < ZONES; i++) set_zone(i, 1'b0, now);
    endfunction

    function automatic void schedule_tick(t_zone_cmd c);
        bit any_on;
        bit started;
        bit [CFG_DATA_W-1:0] w;
        any_on  = 1'b0;
        started = 1'b0;
        for (int i = 0; i < ZONES; i++)
            if (zone_on[i] && secs_elapsed(i, c.now) >= {16'b0, run_limit(i)})
                set_zone(i, 1'b0, c.now);
        if (rain_seen_q && rain_ovr_q) return;
        for (int i = 0; i < ZONES; i++)
            if (zone_on[i]) any_on = 1'b1;
        if (any_on) return;
        for (int i = 0; i < ZONES; i++) begin
            w = sched_word[i];
            // lowest matching zone wins, weekday 7 never matches
            if (!started && w[0] && c.wday != 3'd7 && w[int'(c.wday) + 1] &&
                c.hour == w[12:8] && c.minute == w[18:13]) begin
                set_zone(i, 1'b1, c.now);
                started = 1'b1;
            end
        end
    endfunction

    function automatic t_relay_status zone_update(t_zone_cmd c);
        t_relay_status st;
        longint rem;
        int z;
        bit raining;
        z = int'(c.zone);
        raining = !c.rain_pin;
        case (c.func)
            FN_TICK: begin
                if (c.synced) schedule_tick(c);
            end
            FN_ON:     set_zone(z, 1'b1, c.now);
            FN_OFF:    set_zone(z, 1'b0, c.now);
            FN_ALLOFF: drop_all_zones(c.now);
            FN_RUN: begin
                if (z < ZONES) begin
                    zone_ovr[z] = c.secs;
                    set_zone(z, 1'b1, c.now);
                end
            end
            FN_RAIN: begin
                if (raining != rain_seen_q) begin
                    rain_seen_q = raining;
                    if (raining && rain_ovr_q) drop_all_zones(c.now);
                end
            end
            default: ;
        endcase
        for (int i = 0; i < OUT_W; i++) begin
            st.active[i] = (i < ZONES) && zone_on[i];
            st.drive[i]  = !st.active[i];
        end
        st.rain    = rain_seen_q;
        st.running = (z < ZONES) && zone_on[z];
        rem = 0;
        if (st.running) rem = longint'(run_limit(z)) - longint'(secs_elapsed(z, c.now));
        st.remain = rem[REM_W-1:0];
        return st;
    endfunction

    function automatic t_zone_cmd mk_cmd(logic [FUNC_W-1:0] func, logic [ZONE_W-1:0] zone,
                                         logic [SECS_W-1:0] secs, logic [MS_W-1:0] now,
                                         logic [HOUR_W-1:0] hour, logic [MIN_W-1:0] minute,
                                         logic [WDAY_W-1:0] wday, logic synced,
                                         logic rain_pin);
        t_zone_cmd c;
        c.func = func;     c.zone = zone;       c.secs = secs;
        c.now = now;       c.hour = hour;       c.minute = minute;
        c.wday = wday;     c.synced = synced;   c.rain_pin = rain_pin;
        return c;
    endfunction

    function automatic bit [CFG_DATA_W-1:0] sched_pack(bit en, bit [6:0] days, bit [4:0] hr,
                                                       bit [5:0] mn, bit [15:0] dur);
        return {dur, mn, hr, days, en};
    endfunction

    // every call starts and ends right after a rising edge
    task automatic send_cmd(input t_zone_cmd c);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= c.func;
        cmd_if.zone_index  <= c.zone;
        cmd_if.run_seconds <= c.secs;
        cmd_if.now_ms      <= c.now;
        cmd_if.hour_now    <= c.hour;
        cmd_if.minute_now  <= c.minute;
        cmd_if.weekday_now <= c.wday;
        cmd_if.time_synced <= c.synced;
        cmd_if.rain_pin    <= c.rain_pin;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_status.push_back(zone_update(c));
        cmds_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < SCHED_REGS) sched_word[idx] = data;
        else if (idx == CFG_RAIN_OVR) rain_ovr_q = data[0];
        @(posedge i_clk);
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_status();
        t_relay_status want;
        if (pending_status.size() == 0) begin
            $error("status transaction with nothing expected");
            mismatch_cnt++;
        end else begin
            want = pending_status.pop_front();
            status_seen++;
            if (res_if.relay_drive !== want.drive) begin
                $error("relay_drive exp %h got %h", want.drive, res_if.relay_drive);
                mismatch_cnt++;
            end
            if (res_if.active_mask !== want.active) begin
                $error("active_mask exp %h got %h", want.active, res_if.active_mask);
                mismatch_cnt++;
            end
            if (res_if.rain_flag !== want.rain) begin
                $error("rain_flag exp %b got %b", want.rain, res_if.rain_flag);
                mismatch_cnt++;
            end
            if (res_if.zone_running !== want.running) begin
                $error("zone_running exp %b got %b", want.running, res_if.zone_running);
                mismatch_cnt++;
            end
            if (res_if.remaining_seconds !== want.remain) begin
                $error("remaining_seconds exp %0d got %0d", want.remain,
                       res_if.remaining_seconds);
                mismatch_cnt++;
            end
        end
    endtask

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_status();
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic test_status_after_reset();
        send_cmd(mk_cmd(FN_STATUS, 3'd0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        // spare func code with every field at its top value
        send_cmd(mk_cmd(FN_SPARE, 3'd7, '1, '1, '1, '1, '1, 1'b1, 1'b1));
    endtask

    task automatic test_manual_control();
        settle();
        write_reg(CFG_ZONE0, sched_pack(1'b0, 7'd0, 5'd0, 6'd0, 16'd5));
        write_reg(CFG_ZONE0 + 3'd5, sched_pack(1'b0, 7'd0, 5'd0, 6'd0, 16'hFFFF));
        send_cmd(mk_cmd(FN_ON, 3'd0, '0, 32'd1000, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_STATUS, 3'd0, '0, 32'd4999, '0, '0, '0, 1'b1, 1'b1));
        // zero run-for falls back to the schedule duration
        send_cmd(mk_cmd(FN_RUN, 3'd5, 16'd0, 32'd0, '0, '0, '0, 1'b1, 1'b1));
        // start just before the ms counter wraps
        send_cmd(mk_cmd(FN_RUN, 3'd1, 16'hFFFF, 32'hFFFF_FF00, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_STATUS, 3'd1, '0, 32'h0001_0000, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_ON, 3'd6, '0, 32'd7, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_RUN, 3'd7, 16'd9, 32'd7, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_OFF, 3'd5, '0, 32'd9000, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_ALLOFF, 3'd1, '0, 32'd9000, '0, '0, '0, 1'b1, 1'b1));
        // zero duration zone read far later: most negative remaining value
        send_cmd(mk_cmd(FN_ON, 3'd2, '0, 32'd0, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_STATUS, 3'd2, '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b1, 1'b1));
        // clock not synced: tick must leave the expired zone alone
        send_cmd(mk_cmd(FN_TICK, 3'd2, '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b1));
    endtask

    task automatic test_schedule_start();
        settle();
        write_reg(CFG_ZONE0 + 3'd1, sched_pack(1'b1, 7'b0000010, 5'd6, 6'd30, 16'd2));
        write_reg(CFG_ZONE0 + 3'd3, sched_pack(1'b1, 7'b0000010, 5'd6, 6'd30, 16'd3));
        write_reg(CFG_ZONE0 + 3'd4, '1);
        send_cmd(mk_cmd(FN_TICK, 3'd1, '0, 32'd10_000, 5'd6, 6'd30, 3'd1, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_TICK, 3'd1, '0, 32'd11_000, 5'd6, 6'd30, 3'd1, 1'b1, 1'b1));
        // expiry then restart inside the same minute
        send_cmd(mk_cmd(FN_TICK, 3'd1, '0, 32'd12_000, 5'd6, 6'd30, 3'd1, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_TICK, 3'd1, '0, 32'd20_000, 5'd6, 6'd30, 3'd7, 1'b1, 1'b1));
        // out-of-range wall time against an all-ones schedule word
        send_cmd(mk_cmd(FN_TICK, 3'd4, '0, 32'd21_000, 5'd31, 6'd63, 3'd0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_ALLOFF, 3'd4, '0, 32'd22_000, '0, '0, '0, 1'b1, 1'b1));
    endtask

    task automatic test_rain_handling();
        settle();
        write_reg(CFG_RAIN_OVR, 35'd1);
        send_cmd(mk_cmd(FN_ON, 3'd3, '0, 32'd50_000, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_RAIN, 3'd3, '0, 32'd51_000, '0, '0, '0, 1'b1, 1'b0));
        // stored rain blocks the scheduled start
        send_cmd(mk_cmd(FN_TICK, 3'd1, '0, 32'd52_000, 5'd6, 6'd30, 3'd1, 1'b1, 1'b0));
        send_cmd(mk_cmd(FN_RAIN, 3'd1, '0, 32'd53_000, '0, '0, '0, 1'b1, 1'b1));
        settle();
        write_reg(CFG_RAIN_OVR, 35'd0);
        send_cmd(mk_cmd(FN_ON, 3'd3, '0, 32'd60_000, '0, '0, '0, 1'b1, 1'b1));
        send_cmd(mk_cmd(FN_RAIN, 3'd3, '0, 32'd61_000, '0, '0, '0, 1'b1, 1'b0));
        send_cmd(mk_cmd(FN_RAIN, 3'd3, '0, 32'd62_000, '0, '0, '0, 1'b1, 1'b0));
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_cycles  = 300;
        for (int i = 0; i < 12; i++)
            send_cmd(mk_cmd((i % 2) ? FN_STATUS : FN_ON, 3'(i % 6), '0, 32'(70_000 + i * 500),
                            '0, '0, '0, 1'b1, 1'b1));
    endtask

    task automatic load_schedules(input int style);
        bit [CFG_DATA_W-1:0] w;
        for (int i = 0; i < SCHED_REGS; i++) begin
            case (style)
                0: w = sched_pack(($urandom_range(3) != 0), 7'($urandom()),
                                  5'($urandom_range(23)), 6'($urandom_range(59)),
                                  16'($urandom_range(1, 12)));
                1: w = (i == 0) ? '1 : (i == 1) ? '0 :
                       sched_pack(1'b1, 7'h7F, 5'($urandom_range(23)),
                                  6'($urandom_range(59)), 16'($urandom_range(0, 6)));
                default: w = {3'($urandom()), 32'($urandom())};
            endcase
            write_reg(CFG_ZONE0 + 3'(i), w);
        end
        write_reg(CFG_RAIN_OVR, 35'($urandom_range(1)));
        write_reg(CFG_IDX_UNUSED, {3'($urandom()), 32'($urandom())});
    endtask

    function automatic t_zone_cmd random_cmd();
        t_zone_cmd c;
        bit [CFG_DATA_W-1:0] w;
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0) wall_ms = $urandom();
        else wall_ms = wall_ms + $urandom_range(4000);
        c = mk_cmd(FN_STATUS, 3'($urandom()), 16'($urandom()), wall_ms, 5'($urandom()),
                   6'($urandom()), 3'($urandom()), 1'($urandom()), 1'($urandom()));
        c.zone = ($urandom_range(6) != 0) ? 3'($urandom_range(5)) : 3'($urandom());
        if (pick < 45) begin
            c.func   = FN_TICK;
            c.synced = ($urandom_range(9) != 0);
            if ($urandom_range(3) != 0) begin
                // aim at a programmed start time
                w = sched_word[$urandom_range(SCHED_REGS - 1)];
                c.hour   = w[12:8];
                c.minute = w[18:13];
                c.wday   = 3'($urandom_range(6));
            end
        end else if (pick < 55) c.func = FN_ON;
        else if (pick < 62) c.func = FN_OFF;
        else if (pick < 65) c.func = FN_ALLOFF;
        else if (pick < 75) begin
            c.func = FN_RUN;
            if ($urandom_range(9) < 7) c.secs = 16'($urandom_range(20));
        end else if (pick < 85) c.func = FN_RAIN;
        else c.func = ($urandom_range(4) == 0) ? FN_SPARE : FN_STATUS;
        return c;
    endfunction

    task automatic test_random_traffic();
        int idle_mix [4];
        int stall_mix[4];
        idle_mix  = '{0, 83, 0, 23};
        stall_mix = '{0, 0, 83, 23};
        for (int p = 0; p < 4; p++) begin
            settle();
            load_schedules((p == 3) ? 0 : p);
            tx_idle_pct  = idle_mix[p];
            rx_stall_pct = stall_mix[p];
            repeat (ITEMS_PER_MIX) send_cmd(random_cmd());
        end
    endtask

    initial begin
        cmd_if.valid       <= 1'b0;
        cmd_if.func        <= FN_STATUS;
        cmd_if.zone_index  <= '0;
        cmd_if.run_seconds <= '0;
        cmd_if.now_ms      <= '0;
        cmd_if.hour_now    <= '0;
        cmd_if.minute_now  <= '0;
        cmd_if.weekday_now <= '0;
        cmd_if.time_synced <= 1'b0;
        cmd_if.rain_pin    <= 1'b1;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        mismatch_cnt = 0;
        cmds_sent    = 0;
        status_seen  = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_cycles  = 0;
        wall_ms      = 32'd100_000;
        clear_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_status_after_reset();
        test_manual_control();
        test_schedule_start();
        test_rain_handling();
        test_backpressure();
        test_random_traffic();
        settle();

        $display("%0d commands sent, %0d status transactions checked", cmds_sent, status_seen);
        $display("directed zone/schedule/rain cases, long output hold, four idle/stall mixes");
        if (mismatch_cnt == 0) begin
            $display("[irrigation_zone_sequencer_core] OK");
        end else begin
            $display("[irrigation_zone_sequencer_core] ERROR");
        end
        $finish;
    end

endmodule
